// File: src/vdfl_pkg.sv
// shared types and constants for the descriptor free list
// no dependencies; used by the top level and its checker
`default_nettype none

package vdfl_pkg;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 6;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC      = 2'd0,
        KIND_FREE       = 2'd1,
        KIND_FREE_CHAIN = 2'd2,
        KIND_SET_LINK   = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

`default_nettype wire

// File: src/vdfl_link_ram.sv
// link memory: one next link and has-next mark per descriptor
// one write port, one read port with registered data and write-to-read forwarding
`default_nettype none

module vdfl_link_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;
    logic [DW-1:0] r_fwd_data;
    logic          r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= r_mem[i_raddr];
        // read and write of the same entry in one cycle: return the new data
        r_fwd_hit  <= i_we && (i_waddr == i_raddr);
        r_fwd_data <= i_wdata;
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_rdata;

endmodule

`default_nettype wire

// File: src/virtq_descriptor_free_list_top.sv
// descriptor free list top level: request sequencer, free head and count
// depends on vdfl_pkg and vdfl_link_ram
`default_nettype none

// Hands out and takes back queue descriptors kept as a linked free list in a
// single link memory (next link plus has-next mark per entry). After reset the
// block runs a clearing pass over every entry that builds the chain
// 0,1,2,... and holds o_in_stall high meanwhile. One request is worked at a
// time: free, set-link and requests answered at once (allocate on an empty
// list, index outside the table) finish from the idle state, allocate first
// reads the head's link in S_ALLOC, and a chain free walks the chain in
// S_WALK with one read-modify-write of the link memory per entry visited;
// the entry that finds the list full ends the walk. A result that finds the
// output register still held waits in S_DONE until the output is no longer
// stalled.
module virtq_descriptor_free_list_top #(
    parameter int RING_ENTRIES = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [vdfl_pkg::KIND_W-1:0] i_kind,
    input  wire logic [vdfl_pkg::IDX_W-1:0]  i_entry_index,
    input  wire logic [vdfl_pkg::IDX_W-1:0]  i_link_target,
    input  wire logic                        i_link_flag,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [vdfl_pkg::STAT_W-1:0]      o_status,
    output logic [vdfl_pkg::IDX_W-1:0]       o_allocated_index,
    output logic [vdfl_pkg::COUNT_W-1:0]     o_free_count
);

    localparam int IW   = $clog2(RING_ENTRIES);
    localparam int CW   = $clog2(RING_ENTRIES + 1);
    localparam int IEXT = (IW > vdfl_pkg::IDX_W) ? IW : vdfl_pkg::IDX_W;
    localparam int CEXT = (CW > vdfl_pkg::COUNT_W) ? CW : vdfl_pkg::COUNT_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ALLOC = 5'b00100,
        S_WALK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                      r_state, n_state;
    logic [IW-1:0]               r_head, n_head;
    logic [CW-1:0]               r_count, n_count;
    logic [IW-1:0]               r_cur, n_cur;
    logic [IW-1:0]               r_clr, n_clr;
    vdfl_pkg::t_status           r_res_status, n_res_status;
    logic [vdfl_pkg::IDX_W-1:0]  r_res_alloc, n_res_alloc;
    logic [vdfl_pkg::COUNT_W-1:0] r_res_count, n_res_count;
    logic                        r_out_valid, n_out_valid;
    vdfl_pkg::t_status           r_out_status, n_out_status;
    logic [vdfl_pkg::IDX_W-1:0]  r_out_alloc, n_out_alloc;
    logic [vdfl_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    logic                        mem_we;
    logic [IW-1:0]               mem_waddr;
    logic [IW:0]                 mem_wdata;
    logic [IW-1:0]               mem_raddr;
    logic [IW:0]                 mem_rdata;
    logic [IW-1:0]               rd_link;
    logic                        rd_mark;

    logic                        accept;
    logic                        out_free;
    logic                        list_full;
    logic                        idx_ok;
    logic                        tgt_ok;
    logic [IEXT-1:0]             idx_ext;
    logic [IEXT-1:0]             tgt_ext;
    logic [IW-1:0]               idx;
    logic [IW-1:0]               tgt;
    logic                        fin;
    vdfl_pkg::t_status           fin_status;
    logic [IW-1:0]               fin_alloc;
    logic [IEXT-1:0]             alloc_ext;
    logic [CEXT-1:0]             count_ext;

    vdfl_link_ram #(
        .DEPTH (RING_ENTRIES),
        .AW    (IW),
        .DW    (IW + 1)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_mark = mem_rdata[IW];
    assign rd_link = mem_rdata[IW-1:0];

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign list_full  = (r_count == CW'(RING_ENTRIES));

    assign idx_ok  = (32'(i_entry_index) < RING_ENTRIES);
    assign tgt_ok  = (32'(i_link_target) < RING_ENTRIES);
    assign idx_ext = IEXT'(i_entry_index);
    assign tgt_ext = IEXT'(i_link_target);
    assign idx     = idx_ext[IW-1:0];
    assign tgt     = tgt_ext[IW-1:0];

    assign alloc_ext = IEXT'(fin_alloc);
    assign count_ext = CEXT'(n_count);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_cur        = r_cur;
        n_clr        = r_clr;
        n_res_status = r_res_status;
        n_res_alloc  = r_res_alloc;
        n_res_count  = r_res_count;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_alloc  = r_out_alloc;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_cur;
        mem_wdata    = {1'b0, r_head};
        mem_raddr    = r_cur;
        fin          = 1'b0;
        fin_status   = vdfl_pkg::ST_OK;
        fin_alloc    = '0;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == IW'(RING_ENTRIES - 1)) begin
                    mem_wdata = '0;
                    n_state   = S_IDLE;
                end else begin
                    mem_wdata = {1'b0, r_clr + IW'(1)};
                    n_clr     = r_clr + IW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (vdfl_pkg::t_kind'(i_kind))
                        vdfl_pkg::KIND_ALLOC: begin
                            if (r_count == '0) begin
                                fin        = 1'b1;
                                fin_status = vdfl_pkg::ST_EMPTY;
                            end else begin
                                mem_raddr = r_head;
                                n_state   = S_ALLOC;
                            end
                        end
                        vdfl_pkg::KIND_FREE: begin
                            fin = 1'b1;
                            if (idx_ok) begin
                                if (list_full) begin
                                    fin_status = vdfl_pkg::ST_FULL;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_waddr = idx;
                                    mem_wdata = {1'b0, r_head};
                                    n_head    = idx;
                                    n_count   = r_count + CW'(1);
                                end
                            end
                        end
                        vdfl_pkg::KIND_FREE_CHAIN: begin
                            if (idx_ok) begin
                                mem_raddr = idx;
                                n_cur     = idx;
                                n_state   = S_WALK;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        vdfl_pkg::KIND_SET_LINK: begin
                            fin = 1'b1;
                            if (idx_ok && tgt_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = idx;
                                mem_wdata = {i_link_flag, tgt};
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                fin       = 1'b1;
                fin_alloc = r_head;
                n_head    = rd_link;
                n_count   = r_count - CW'(1);
            end
            S_WALK: begin
                if (list_full) begin
                    fin        = 1'b1;
                    fin_status = vdfl_pkg::ST_FULL;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_cur;
                    mem_wdata = {1'b0, r_head};
                    n_head    = r_cur;
                    n_count   = r_count + CW'(1);
                    if (rd_mark) begin
                        // next entry read while this one is written back
                        mem_raddr = rd_link;
                        n_cur     = rd_link;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_alloc  = r_res_alloc;
                    n_out_count  = r_res_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = fin_status;
                n_out_alloc  = alloc_ext[vdfl_pkg::IDX_W-1:0];
                n_out_count  = count_ext[vdfl_pkg::COUNT_W-1:0];
                n_state      = S_IDLE;
            end else begin
                n_res_status = fin_status;
                n_res_alloc  = alloc_ext[vdfl_pkg::IDX_W-1:0];
                n_res_count  = count_ext[vdfl_pkg::COUNT_W-1:0];
                n_state      = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_head      <= '0;
            r_count     <= CW'(RING_ENTRIES);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_res_status <= n_res_status;
        r_res_alloc  <= n_res_alloc;
        r_res_count  <= n_res_count;
        r_out_status <= n_out_status;
        r_out_alloc  <= n_out_alloc;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_allocated_index = r_out_alloc;
    assign o_free_count      = r_out_count;

endmodule

`default_nettype wire

// File: src/vdfl_checker.sv
// port-level checks for the descriptor free list, bound to the top level
// depends on vdfl_pkg
`default_nettype none

module vdfl_checker #(
    parameter int RING_ENTRIES = 64
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic [vdfl_pkg::KIND_W-1:0] i_kind,
    input wire logic [vdfl_pkg::IDX_W-1:0]  i_entry_index,
    input wire logic [vdfl_pkg::IDX_W-1:0]  i_link_target,
    input wire logic                        i_link_flag,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [vdfl_pkg::STAT_W-1:0] o_status,
    input wire logic [vdfl_pkg::IDX_W-1:0]  o_allocated_index,
    input wire logic [vdfl_pkg::COUNT_W-1:0] o_free_count
);

    // a stalled request beat stays offered with the same payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_kind)
            && $stable(i_entry_index) && $stable(i_link_target)
            && $stable(i_link_flag))
        else $error("request beat changed while stalled");

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_allocated_index) && $stable(o_free_count))
        else $error("result beat changed while stalled");

    // no result comes out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an empty answer reports zero free and no descriptor
    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == vdfl_pkg::ST_EMPTY)
            |-> (o_free_count == '0) && (o_allocated_index == '0))
        else $error("empty status with nonzero count or index");

    // a refused free only happens with every descriptor free
    a_full_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == vdfl_pkg::ST_FULL)
            |-> (o_free_count == vdfl_pkg::COUNT_W'(RING_ENTRIES))
                && (o_allocated_index == '0))
        else $error("full status while list not full");

endmodule

bind virtq_descriptor_free_list_top vdfl_checker #(
    .RING_ENTRIES (RING_ENTRIES)
) u_vdfl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_kind            (i_kind),
    .i_entry_index     (i_entry_index),
    .i_link_target     (i_link_target),
    .i_link_flag       (i_link_flag),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_status          (o_status),
    .o_allocated_index (o_allocated_index),
    .o_free_count      (o_free_count)
);

`default_nettype wire
